>>> hdl/windowed_sinc_table_gen_assert.svh
// ----------------------------------------------------------------------------
// windowed_sinc_table_gen assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_SINC_TABLE_GEN_ASSERT_SVH
`define WINDOWED_SINC_TABLE_GEN_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define WSTG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define WSTG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WSTG_ASSERT_NOW(lbl, ante, cons)
`define WSTG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hdl/wsinc_pkg.sv
// ----------------------------------------------------------------------------
// wsinc_pkg
// Shared constants and types of the windowed sinc coefficient generator.
// ----------------------------------------------------------------------------
package wsinc_pkg;

  localparam int COEFF_FRAC_BITS_DEF = 15;

  localparam int LEN_W = 14;
  localparam int H_W   = 13;
  localparam logic [LEN_W-1:0] LEN_RESET = 14'd2047;

  localparam logic [41:0] PI_Q40      = 42'd3454217652358;
  localparam logic [33:0] PI_SQ_Q30   = 34'd10597407032;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [29:0] WIN_A_Q30   = 30'd579820585;
  localparam logic [28:0] WIN_B_Q30   = 29'd493921239;

  // Horner divisors and floor(2^32 / divisor)
  localparam int TAYLOR_N = 6;
  localparam logic [7:0]  TAYLOR_DIV [TAYLOR_N] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [29:0] TAYLOR_RCP [TAYLOR_N] = '{30'd27531841, 30'd39045157, 30'd59652323,
                                                    30'd102261126, 30'd214748364, 30'd715827882};

  // divider geometry
  localparam int PH_NUM_W   = 56;  // d * pi (Q40)
  localparam int PH_DEN_W   = 14;  // 2h
  localparam int PH_Q_W     = 40;
  localparam int ARG_NUM_W  = 48;  // d * pi^2 (Q30)
  localparam int ARG_DEN_W  = 13;  // h
  localparam int WIN_NUM_W  = 46;  // i << 32
  localparam int WIN_DEN_W  = 14;  // n
  localparam int WIN_Q_W    = 32;
  localparam int SINC_NUM_W = 62;  // sin << 30
  localparam int SINC_STEPS = 32;

  typedef struct packed {
    logic [31:0] x2;
    logic [30:0] x;
    logic [1:0]  quad;
  } lane_car_t;

endpackage

>>> hdl/wsinc_div.sv
// ----------------------------------------------------------------------------
// wsinc_div
// Pipelined restoring divider, one quotient bit per stage, stall by enable.
// ----------------------------------------------------------------------------
module wsinc_div #(
  parameter int NUM_W = wsinc_pkg::PH_NUM_W,
  parameter int DEN_W = wsinc_pkg::PH_DEN_W,
  parameter int STEPS = wsinc_pkg::PH_NUM_W,
  parameter int Q_W   = wsinc_pkg::PH_Q_W
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);

  logic [DEN_W-1:0] rem_r [1:STEPS-1];
  logic [Q_W-1:0]   q_r   [1:STEPS];
  logic [STEPS-1:0] lo_r  [1:STEPS-1];
  logic [DEN_W-1:0] den_r [1:STEPS-1];

  for (genvar k = 1; k <= STEPS; k++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [STEPS-1:0] lo_in;
    logic [Q_W-1:0]   q_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 1) begin : g_first
      // dividend bits above STEPS seed the remainder (kept below den)
      assign rem_in = DEN_W'(num >> STEPS);
      assign lo_in  = num[STEPS-1:0];
      assign q_in   = '0;
      assign den_in = den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign lo_in  = lo_r[k-1];
      assign q_in   = q_r[k-1];
      assign den_in = den_r[k-1];
    end

    assign trial = {rem_in, lo_in[STEPS-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= {q_in[Q_W-2:0], ge};
      end
    end

    if (k < STEPS) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          lo_r[k]  <= lo_in << 1;
          den_r[k] <= den_in;
        end
      end
    end
  end

  assign quo = q_r[STEPS];

endmodule

>>> hdl/windowed_sinc_table_gen.sv
// ----------------------------------------------------------------------------
// windowed_sinc_table_gen
// Hamming-windowed sinc coefficient per table index, signed Q1.15 out.
// ----------------------------------------------------------------------------
//  channel | dir | ports                          | word
//  --------+-----+--------------------------------+---------------------------
//  in      | in  | in_tvalid/in_tready/in_tdata   | [13:0] entry_index
//  out     | out | out_tvalid/out_tready/out_tdata| [15:0] coefficient
//  cfg     | in  | cfg_wr_en/cfg_wr_data          | [13:0] table_length
//
//  One word per cycle while not stalled. Latency is set
//  by the 56-step phase divider, the 22-stage sine/cosine lanes and the
//  32-step sinc divider in series. All stages share one enable, which drops
//  only when the last stage and the output register both hold words and
//  out_tready is low. rst_n clears valid bits and sets table_length to 2047.
// ----------------------------------------------------------------------------
`include "windowed_sinc_table_gen_assert.svh"

module windowed_sinc_table_gen #(
  parameter int COEFF_FRAC_BITS = wsinc_pkg::COEFF_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [13:0] entry_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [15:0] coefficient
  input  logic        cfg_wr_en,
  input  logic [13:0] cfg_wr_data  // table_length
);

  localparam int ST_MUL   = 1;
  localparam int PH_DONE  = ST_MUL + wsinc_pkg::PH_NUM_W;
  localparam int ARG_DONE = ST_MUL + wsinc_pkg::ARG_NUM_W;
  localparam int WIN_DONE = ST_MUL + wsinc_pkg::WIN_NUM_W;
  localparam int ST_PH    = PH_DONE + 1;
  localparam int LANE_STG = 3 + 3 * wsinc_pkg::TAYLOR_N + 1;
  localparam int ST_SIN   = ST_PH + LANE_STG;
  localparam int ST_SQ    = ST_SIN + wsinc_pkg::SINC_STEPS;
  localparam int ST_M     = ST_SQ + 1;
  localparam int LAST     = ST_M + 1;
  localparam int WIN_DLY  = PH_DONE - WIN_DONE;
  localparam int ARG_DLY  = ST_SIN - ARG_DONE;
  localparam int NEG_DLY  = ST_SQ - ST_SIN;
  localparam int W_DLY    = ST_SQ - (ST_SIN + 2);
  localparam int CAR_N    = 3 * wsinc_pkg::TAYLOR_N;

  localparam int SHIFT = 30 - COEFF_FRAC_BITS;
  localparam logic [33:0] RND = (34'd1 << SHIFT) >> 1;
  localparam logic [33:0] LIM = (34'd1 << COEFF_FRAC_BITS) - 34'd1;
  localparam logic [33:0] NEG_MAX = 34'd32768;
  localparam logic [33:0] POS_MAX = 34'd32767;

  // ---------------- control ----------------
  logic [13:0]   table_length_r;
  logic [LAST:0] vld_r;
  logic          out_valid_r;
  logic [15:0]   out_data_r;
  logic          out_ld;
  logic          en;

  assign out_ld    = !out_valid_r || out_tready;
  assign en        = !vld_r[LAST] || out_ld;
  assign in_tready = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_length_r <= wsinc_pkg::LEN_RESET;
    end else if (cfg_wr_en) begin
      table_length_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[LAST-1:0], in_tvalid};
      end
      if (out_ld) begin
        out_valid_r <= vld_r[LAST];
      end
    end
  end

  // ---------------- stage 0: index, length, half length ----------------
  logic [13:0] len_eff;
  logic [12:0] h_nxt;
  logic [13:0] i_nxt;
  logic [13:0] d_nxt;
  logic [13:0] len_m1;

  logic [13:0] i0_r;
  logic [13:0] n0_r;
  logic [12:0] h0_r;
  logic [13:0] d0_r;
  logic        cen_r [0:ST_SQ];

  assign len_eff = (table_length_r == 14'd0) ? 14'd1 : table_length_r;
  assign len_m1  = len_eff - 14'd1;
  assign h_nxt   = len_m1[13:1];
  assign i_nxt   = in_tdata[13:0];
  assign d_nxt   = (i_nxt > {1'b0, h_nxt}) ? i_nxt - {1'b0, h_nxt} : {1'b0, h_nxt} - i_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      i0_r     <= i_nxt;
      n0_r     <= len_eff;
      h0_r     <= h_nxt;
      d0_r     <= d_nxt;
      // centre index or length of at most two: sinc is exactly one
      cen_r[0] <= (h_nxt == 13'd0) || (i_nxt == {1'b0, h_nxt});
      for (int k = 1; k <= ST_SQ; k++) begin
        cen_r[k] <= cen_r[k-1];
      end
    end
  end

  // ---------------- stage 1: dividends ----------------
  logic [wsinc_pkg::PH_NUM_W-1:0]  num_ph_r;
  logic [wsinc_pkg::ARG_NUM_W-1:0] num_arg_r;
  logic [wsinc_pkg::WIN_NUM_W-1:0] num_win_r;
  logic [wsinc_pkg::PH_DEN_W-1:0]  den_ph_r;
  logic [wsinc_pkg::ARG_DEN_W-1:0] den_arg_r;
  logic [wsinc_pkg::WIN_DEN_W-1:0] den_win_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num_ph_r  <= wsinc_pkg::PH_NUM_W'(d0_r) * wsinc_pkg::PH_NUM_W'(wsinc_pkg::PI_Q40);
      num_arg_r <= wsinc_pkg::ARG_NUM_W'(d0_r) * wsinc_pkg::ARG_NUM_W'(wsinc_pkg::PI_SQ_Q30);
      num_win_r <= {i0_r, 32'd0};
      den_ph_r  <= {h0_r, 1'b0};
      den_arg_r <= h0_r;
      den_win_r <= n0_r;
    end
  end

  logic [wsinc_pkg::PH_Q_W-1:0]    q_ph;
  logic [wsinc_pkg::ARG_NUM_W-1:0] q_arg;
  logic [wsinc_pkg::WIN_Q_W-1:0]   q_win;

  wsinc_div #(
    .NUM_W(wsinc_pkg::PH_NUM_W), .DEN_W(wsinc_pkg::PH_DEN_W),
    .STEPS(wsinc_pkg::PH_NUM_W), .Q_W(wsinc_pkg::PH_Q_W)
  ) u_div_ph (
    .clk(clk), .en(en), .num(num_ph_r), .den(den_ph_r), .quo(q_ph)
  );

  wsinc_div #(
    .NUM_W(wsinc_pkg::ARG_NUM_W), .DEN_W(wsinc_pkg::ARG_DEN_W),
    .STEPS(wsinc_pkg::ARG_NUM_W), .Q_W(wsinc_pkg::ARG_NUM_W)
  ) u_div_arg (
    .clk(clk), .en(en), .num(num_arg_r), .den(den_arg_r), .quo(q_arg)
  );

  wsinc_div #(
    .NUM_W(wsinc_pkg::WIN_NUM_W), .DEN_W(wsinc_pkg::WIN_DEN_W),
    .STEPS(wsinc_pkg::WIN_NUM_W), .Q_W(wsinc_pkg::WIN_Q_W)
  ) u_div_win (
    .clk(clk), .en(en), .num(num_win_r), .den(den_win_r), .quo(q_win)
  );

  // align window phase and sinc argument
  logic [wsinc_pkg::WIN_Q_W-1:0]   win_q_r [1:WIN_DLY];
  logic [wsinc_pkg::ARG_NUM_W-1:0] a_r     [1:ARG_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      win_q_r[1] <= q_win;
      for (int k = 2; k <= WIN_DLY; k++) begin
        win_q_r[k] <= win_q_r[k-1];
      end
      a_r[1] <= q_arg;
      for (int k = 2; k <= ARG_DLY; k++) begin
        a_r[k] <= a_r[k-1];
      end
    end
  end

  // ---------------- phases: lane 0 sinc sine, lane 1 window cosine ----------------
  logic [31:0] ph_r   [2];
  logic [31:0] s_r    [2];
  logic        sneg_r [2];

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r[0] <= q_ph[39:8];
      ph_r[1] <= win_q_r[WIN_DLY] + wsinc_pkg::QUARTER_TURN;
    end
  end

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    logic [30:0]           r_r;
    logic [1:0]            qa_r;
    logic [30:0]           x_r;
    logic [1:0]            qb_r;
    wsinc_pkg::lane_car_t  car_r  [0:CAR_N];
    logic [31:0]           va_r   [wsinc_pkg::TAYLOR_N];
    logic [31:0]           vb_r   [wsinc_pkg::TAYLOR_N];
    logic [29:0]           q0_r   [wsinc_pkg::TAYLOR_N];
    logic [30:0]           term_r [wsinc_pkg::TAYLOR_N];
    logic [61:0]           x_prod;
    logic [61:0]           x2_prod;
    logic [61:0]           s_prod;
    logic [30:0]           r_nxt;

    // fold into the first quarter turn
    assign r_nxt   = ph_r[ln][30] ? wsinc_pkg::Q30_ONE - {1'b0, ph_r[ln][29:0]}
                                  : {1'b0, ph_r[ln][29:0]};
    assign x_prod  = 62'(r_r) * 62'(wsinc_pkg::HALF_PI_Q30);
    assign x2_prod = 62'(x_r) * 62'(x_r);
    assign s_prod  = 62'(car_r[CAR_N].x) * 62'(term_r[wsinc_pkg::TAYLOR_N-1]);

    always_ff @(posedge clk) begin
      if (en) begin
        r_r        <= r_nxt;
        qa_r       <= ph_r[ln][31:30];
        x_r        <= x_prod[60:30];
        qb_r       <= qa_r;
        car_r[0]   <= '{x2: x2_prod[61:30], x: x_r, quad: qb_r};
        s_r[ln]    <= s_prod[61:30];
        sneg_r[ln] <= car_r[CAR_N].quad[1] && (s_prod[61:30] != 32'd0);
      end
    end

    for (genvar k = 0; k < wsinc_pkg::TAYLOR_N; k++) begin : g_horner
      logic [30:0] term_in;
      logic [62:0] p_a;
      logic [61:0] p_b;
      logic [32:0] rem_c;
      logic [29:0] q_c;

      if (k == 0) begin : g_t0
        assign term_in = wsinc_pkg::Q30_ONE;
      end else begin : g_tk
        assign term_in = term_r[k-1];
      end

      assign p_a = 63'(car_r[3*k].x2) * 63'(term_in);
      // reciprocal estimate is low by at most one
      assign p_b   = 62'(va_r[k]) * 62'(wsinc_pkg::TAYLOR_RCP[k]);
      assign rem_c = {1'b0, vb_r[k]} - 33'(q0_r[k]) * 33'(wsinc_pkg::TAYLOR_DIV[k]);
      assign q_c   = q0_r[k] + 30'(rem_c >= 33'(wsinc_pkg::TAYLOR_DIV[k]));

      always_ff @(posedge clk) begin
        if (en) begin
          va_r[k]       <= p_a[61:30];
          car_r[3*k+1]  <= car_r[3*k];
          vb_r[k]       <= va_r[k];
          q0_r[k]       <= p_b[61:32];
          car_r[3*k+2]  <= car_r[3*k+1];
          term_r[k]     <= wsinc_pkg::Q30_ONE - {1'b0, q_c};
          car_r[3*k+3]  <= car_r[3*k+2];
        end
      end
    end
  end

  // ---------------- window ----------------
  logic [60:0] wp_prod;
  logic [30:0] wp_r;
  logic        wneg_r;
  logic [30:0] w_r [0:W_DLY];

  assign wp_prod = 61'(wsinc_pkg::WIN_B_Q30) * 61'(s_r[1]);

  always_ff @(posedge clk) begin
    if (en) begin
      wp_r   <= wp_prod[60:30];
      wneg_r <= sneg_r[1];
      w_r[0] <= wneg_r ? 31'(wsinc_pkg::WIN_A_Q30) + wp_r : 31'(wsinc_pkg::WIN_A_Q30) - wp_r;
      for (int k = 1; k <= W_DLY; k++) begin
        w_r[k] <= w_r[k-1];
      end
    end
  end

  // ---------------- sinc = sin / argument ----------------
  logic [wsinc_pkg::SINC_NUM_W-1:0] num_sinc;
  logic [31:0]                      q_sinc;
  logic                             ng_r [1:NEG_DLY];

  assign num_sinc = {s_r[0], 30'd0};

  wsinc_div #(
    .NUM_W(wsinc_pkg::SINC_NUM_W), .DEN_W(wsinc_pkg::ARG_NUM_W),
    .STEPS(wsinc_pkg::SINC_STEPS), .Q_W(wsinc_pkg::SINC_STEPS)
  ) u_div_sinc (
    .clk(clk), .en(en), .num(num_sinc), .den(a_r[ARG_DLY]), .quo(q_sinc)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ng_r[1] <= sneg_r[0];
      for (int k = 2; k <= NEG_DLY; k++) begin
        ng_r[k] <= ng_r[k-1];
      end
    end
  end

  // ---------------- product, rounding, saturation ----------------
  logic [31:0] sinc_v;
  logic [62:0] m_prod;
  logic [32:0] m_r;
  logic        negf_r;
  logic [33:0] m_rnd;
  logic [33:0] m_lim;
  logic [33:0] mag;
  logic        neg_nxt;
  logic [15:0] coef_nxt;
  logic [15:0] coef_r;

  assign sinc_v = cen_r[ST_SQ] ? 32'(wsinc_pkg::Q30_ONE) : q_sinc;
  assign m_prod = 63'(sinc_v) * 63'(w_r[W_DLY]);

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= m_prod[62:30];
      negf_r <= ng_r[NEG_DLY] && !cen_r[ST_SQ];
    end
  end

  always_comb begin
    m_rnd   = ({1'b0, m_r} + RND) >> SHIFT;
    m_lim   = (m_rnd > LIM) ? LIM : m_rnd;
    neg_nxt = negf_r && (m_lim != 34'd0);
    if (neg_nxt) begin
      mag      = (m_lim > NEG_MAX) ? NEG_MAX : m_lim;
      coef_nxt = 16'(17'h10000 - mag[16:0]);
    end else begin
      mag      = (m_lim > POS_MAX) ? POS_MAX : m_lim;
      coef_nxt = mag[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coef_r <= coef_nxt;
    end
    if (out_ld) begin
      out_data_r <= coef_r;
    end
  end

  // ---------------- checks ----------------
  `WSTG_ASSERT_NOW(a_stall_cause, !in_tready, vld_r[LAST] && out_valid_r && !out_tready)
  `WSTG_ASSERT_NEXT(a_last_moves_out, vld_r[LAST] && en, out_valid_r)
  `WSTG_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_r))

endmodule

>>> verif/windowed_sinc_table_gen_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_sinc_table_gen_checker
// Watches the entry_index and coefficient streams and the table_length port,
// predicts each coefficient in fixed point and compares it in order.
// ----------------------------------------------------------------------------
module windowed_sinc_table_gen_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,    // [13:0] entry_index
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,   // [15:0] coefficient
  input  logic        cfg_wr_en,
  input  logic [13:0] cfg_wr_data, // table_length
  output int          mismatches,
  output int          coeffs_pending
);

  typedef longint unsigned u64_t;

  localparam u64_t ONE_Q30    = 64'd1073741824;
  localparam u64_t HPI_Q30    = 64'd1686629713;
  localparam u64_t PI_Q40V    = 64'd3454217652358;
  localparam u64_t PI2_Q30    = 64'd10597407032;
  localparam u64_t HAM_A_Q30  = 64'd579820585;
  localparam u64_t HAM_B_Q30  = 64'd493921239;
  localparam int   FRAC_BITS  = 15;

  logic [13:0]  len_cfg;
  logic [15:0]  coeff_q[$];
  logic [13:0]  index_q[$];

  // sine of a Q32 turn: Q30 magnitude plus sign
  function automatic u64_t turn_sine(input logic [31:0] ph, output bit neg);
    u64_t r, x, x2, t, s;
    u64_t divs [6];
    divs = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    r = u64_t'(ph[29:0]);
    if (ph[30]) r = ONE_Q30 - r;
    x  = (r * HPI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (int k = 0; k < 6; k++) t = ONE_Q30 - ((x2 * t) >> 30) / divs[k];
    s = (x * t) >> 30;
    neg = ph[31] && (s != 0);
    return s;
  endfunction

  function automatic logic [15:0] kernel_coeff(input logic [13:0] len,
                                               input logic [13:0] idx);
    u64_t n, i, h, d, sm, a, c, w, m, lim;
    bit neg, cneg;
    logic [31:0] ph;
    n = u64_t'(len);
    i = u64_t'(idx);
    neg = 0;
    if (n == 0) n = 1;
    h = (n - 1) / 2;
    if (h == 0 || i == h) begin
      sm = ONE_Q30;
    end else begin
      d  = (i > h) ? i - h : h - i;
      ph = 32'(((d * PI_Q40V) / (2 * h)) >> 8);
      sm = turn_sine(ph, neg);
      a  = (PI2_Q30 * d) / h;
      sm = (a != 0) ? (sm << 30) / a : ONE_Q30;
    end
    ph = 32'(((i % n) << 32) / n);
    c  = turn_sine(ph + 32'h4000_0000, cneg);
    c  = (HAM_B_Q30 * c) >> 30;
    w  = cneg ? HAM_A_Q30 + c : HAM_A_Q30 - c;
    m  = (sm * w) >> 30;
    m  = (m + (u64_t'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    lim = (u64_t'(1) << FRAC_BITS) - 1;
    if (m > lim) m = lim;
    if (m == 0) neg = 0;
    if (neg) begin
      if (m > 32768) m = 32768;
      return 16'(17'h10000 - 17'(m));
    end
    if (m > 32767) m = 32767;
    return 16'(m);
  endfunction

  task automatic report(input string what, input logic [13:0] idx,
                        input logic [15:0] got, input logic [15:0] want);
    $display("MISMATCH %s: len=%0d index=%0d got=%0d want=%0d", what, len_cfg,
             idx, $signed(got), $signed(want));
    mismatches++;
  endtask

  assign coeffs_pending = coeff_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      len_cfg <= 14'd2047;
      mismatches = 0;
    end else begin
      if (cfg_wr_en) len_cfg <= cfg_wr_data;
      if (in_tvalid && in_tready) begin
        coeff_q.push_back(kernel_coeff(len_cfg, in_tdata[13:0]));
        index_q.push_back(in_tdata[13:0]);
      end
      if (out_tvalid && out_tready) begin
        if (coeff_q.size() == 0) begin
          report("unexpected word", 14'd0, out_tdata, 16'd0);
        end else begin
          if (out_tdata !== coeff_q[0])
            report("coefficient", index_q[0], out_tdata, coeff_q[0]);
          void'(coeff_q.pop_front());
          void'(index_q.pop_front());
        end
      end
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the windowed sinc coefficient generator: several table
// lengths, corner indices, random indices, random stalls on both streams.
// ----------------------------------------------------------------------------
module tb;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [13:0] entry_index
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // [15:0] coefficient
  logic        cfg_wr_en;
  logic [13:0] cfg_wr_data; // table_length
  int          mismatches;
  int          coeffs_pending;
  bit          no_stalls;
  bit          hold_req;
  int          idle_cycles;

  windowed_sinc_table_gen DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  windowed_sinc_table_gen_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .mismatches(mismatches), .coeffs_pending(coeffs_pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (no_stalls) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_index(input logic [13:0] idx);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // drain, then let the pipeline settle before touching table_length
  task automatic set_length(input logic [13:0] len);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (coeffs_pending != 0) @(posedge clk);
    repeat (130) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [13:0] len, input int count);
    int h;
    h = (len == 0) ? 0 : (len - 1) / 2;
    send_index(14'd0);
    send_index(14'(h));
    if (h > 0) send_index(14'(h - 1));
    send_index(14'(h + 1));
    send_index(len - 14'd1);
    send_index(14'd16382);
    send_index(14'd1);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 8) send_index(14'($urandom_range(0, len - 1)));
      else send_index(14'($urandom_range(0, 16382)));
    end
  endtask

  // receiver; a toggle of hold_req asks for one long hold
  initial begin
    int stall;
    bit hold_seen;
    out_tready = 1'b0;
    hold_seen = 0;
    stall = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      if (stall == 0) stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // watchdog on cycles with no word moving on either stream
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("windowed_sinc_table_gen test failed");
      $finish;
    end
  end

  initial begin
    logic [13:0] lens [10];
    lens = '{14'd2047, 14'd1, 14'd3, 14'd16383, 14'd2048, 14'd5, 14'd15,
             14'd0, 14'd0, 14'd255};
    lens[7] = 14'($urandom_range(3, 8191) | 1);
    lens[8] = 14'($urandom_range(8192, 16383) | 1);
    no_stalls = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < 10; p++) begin
      if (p > 0) set_length(lens[p]);
      // back-to-back words during a long hold fill the pipeline
      no_stalls = (p == 2 || p == 3 || p == 5 || p == 6);
      if (p == 2 || p == 5) hold_req = ~hold_req;
      run_phase(lens[p], 70);
      if (!(p == 2 || p == 5)) begin
        // sender waits for a full drain mid phase
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (coeffs_pending != 0) @(posedge clk);
      end
      run_phase(lens[p], 60);
    end
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (coeffs_pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (mismatches == 0) $display("windowed_sinc_table_gen test passed");
    else $display("windowed_sinc_table_gen test failed");
    $finish;
  end

endmodule
